/* src/tlptm_pkg.sv */
`default_nettype none

package tlptm_pkg;

  // Table store sizing
  localparam int NUM_TABLES  = 64;
  localparam int IDX_W       = 10;
  localparam int OFS_W       = 12;
  localparam int FRAME_W     = 20;
  localparam int DIR_DEPTH   = 1024;
  localparam int TBL_ENTRIES = 1024;
  localparam int SLOT_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int NF_W        = $clog2(NUM_TABLES + 1);
  localparam int TBL_AW      = SLOT_W + IDX_W;
  localparam int TBL_DEPTH   = NUM_TABLES * TBL_ENTRIES;

  // Directory entry: {slot, user, writable, present}
  localparam int DIR_W  = SLOT_W + 3;
  localparam int ENT_P  = 0;
  localparam int ENT_WR = 1;
  localparam int ENT_U  = 2;

  // Virtual address fields
  localparam int DI_LSB = OFS_W + IDX_W;
  localparam int TI_LSB = OFS_W;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_XLATE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_READ
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_MAPPED,
    RES_OOT,
    RES_XLATE
  } res_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic dir_alloc;
    logic tbl_wr_map;
    logic tbl_wr_clr;
    logic tbl_rd;
    logic out_load;
    res_t res;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic dir_present;
    logic tables_left;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

/* src/tlptm_req_if.sv */
`default_nettype none

interface tlptm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] virt_addr;
  logic [31:0] frame_addr;
  logic [11:0] entry_flags;

  modport source (output valid, op, virt_addr, frame_addr, entry_flags, input ready);
  modport sink   (input valid, op, virt_addr, frame_addr, entry_flags, output ready);
endinterface

`default_nettype wire

/* src/tlptm_rsp_if.sv */
`default_nettype none

interface tlptm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] phys_addr;
  logic        mapped;
  logic        out_of_tables;

  modport source (output valid, phys_addr, mapped, out_of_tables, input ready);
  modport sink   (input valid, phys_addr, mapped, out_of_tables, output ready);
endinterface

`default_nettype wire

/* src/two_level_page_table_manager_unit.sv */
// Two-level page table manager: a 1024-entry page directory and a store of
// NUM_TABLES page tables of 1024 entries, each in a single-port-write memory
// with a registered read. After reset the block runs a clearing pass that
// writes every table store entry once (the directory is rewritten while the
// pass is in table 0) and holds in_req.ready low until it is done. After
// that, the directory entry is read at the accepting edge. In the lookup
// step map and unmap write the table entry where a table exists or is
// allocated, and map, unmap, the unused op code and a translate that misses
// in the directory load the result register. A translate that hits reads the
// table in the lookup step and loads the result register in the table read
// step. One beat is handled at a time. A result waits in the output register
// while the next beat is accepted; the block stalls in its lookup or table
// read step only while that register still holds a result not yet taken.
`default_nettype none

module two_level_page_table_manager_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tlptm_req_if.sink        in_req,
  tlptm_rsp_if.source      out_rsp
);

  tlptm_pkg::cmd_t cmd;
  tlptm_pkg::sts_t sts;
  logic            in_ready;

  tlptm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlptm_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_req.op),
    .in_virt_addr      (in_req.virt_addr),
    .in_frame_addr     (in_req.frame_addr),
    .in_entry_flags    (in_req.entry_flags),
    .out_valid         (out_rsp.valid),
    .out_ready         (out_rsp.ready),
    .out_phys_addr     (out_rsp.phys_addr),
    .out_mapped        (out_rsp.mapped),
    .out_out_of_tables (out_rsp.out_of_tables)
  );

  assign in_req.ready = in_ready;

`ifndef SYNTHESIS
  // one beat in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("beat accepted while previous one still in lookup");

  // allocation only for an absent slot with tables remaining
  a_alloc_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dir_alloc |-> (sts.tables_left && !sts.dir_present))
    else $error("table allocated without need or beyond the store");

  // success and exhaustion exclude each other
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> !(out_rsp.mapped && out_rsp.out_of_tables))
    else $error("mapped and out_of_tables both set");

  // a nonzero address only comes with a hit
  a_phys_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && (out_rsp.phys_addr != 32'd0)) |-> out_rsp.mapped)
    else $error("physical address given without a mapping");
`endif

endmodule

`default_nettype wire

/* src/tlptm_dpath.sv */
`default_nettype none

module tlptm_dpath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tlptm_pkg::cmd_t    cmd,
  output tlptm_pkg::sts_t         sts,
  input  wire logic [1:0]         in_op,
  input  wire logic [31:0]        in_virt_addr,
  input  wire logic [31:0]        in_frame_addr,
  input  wire logic [11:0]        in_entry_flags,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_phys_addr,
  output logic                    out_mapped,
  output logic                    out_out_of_tables
);

  // Memories
  logic [tlptm_pkg::DIR_W-1:0]     dir_mem [tlptm_pkg::DIR_DEPTH];
  logic [tlptm_pkg::FRAME_W:0]     tbl_mem [tlptm_pkg::TBL_DEPTH];

  // Captured beat
  tlptm_pkg::op_t                  op_r;
  logic [31:0]                     va_r;
  logic [tlptm_pkg::FRAME_W-1:0]   frame_r;
  logic                            user_r;

  // Read data
  logic [tlptm_pkg::DIR_W-1:0]     dir_q_r;
  logic [tlptm_pkg::FRAME_W:0]     tbl_q_r;

  // Control state
  logic [tlptm_pkg::NF_W-1:0]      next_free_r, next_free_nxt;
  logic [tlptm_pkg::TBL_AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // Result payload
  logic [31:0]                     phys_r;
  logic                            mapped_r;
  logic                            oot_r;

  logic                            dir_present;
  logic [tlptm_pkg::SLOT_W-1:0]    use_slot;
  logic [tlptm_pkg::TBL_AW-1:0]    tbl_addr;
  logic                            tbl_we;
  logic [tlptm_pkg::TBL_AW-1:0]    tbl_waddr;
  logic [tlptm_pkg::FRAME_W:0]     tbl_wdata;
  logic                            dir_we;
  logic [tlptm_pkg::IDX_W-1:0]     dir_waddr;
  logic [tlptm_pkg::DIR_W-1:0]     dir_wdata;
  logic                            clr_in_dir;
  logic                            clr_slot0;

  assign dir_present = dir_q_r[tlptm_pkg::ENT_P];
  // Existing table, or the one about to be allocated
  assign use_slot = dir_present ? dir_q_r[tlptm_pkg::DIR_W-1:3]
                                : next_free_r[tlptm_pkg::SLOT_W-1:0];
  assign tbl_addr = {use_slot, va_r[tlptm_pkg::TI_LSB +: tlptm_pkg::IDX_W]};

  assign clr_in_dir = (clr_cnt_r[tlptm_pkg::TBL_AW-1:tlptm_pkg::IDX_W] == '0);
  assign clr_slot0  = clr_in_dir;

  // Table store write port
  always_comb begin
    tbl_we    = cmd.clr_step | cmd.tbl_wr_map | cmd.tbl_wr_clr;
    tbl_waddr = tbl_addr;
    tbl_wdata = '0;
    if (cmd.clr_step) begin
      tbl_waddr = clr_cnt_r;
      if (clr_slot0) begin
        // table 0 maps the first 4 MB onto itself
        tbl_wdata = {{(tlptm_pkg::FRAME_W - tlptm_pkg::IDX_W){1'b0}},
                     clr_cnt_r[tlptm_pkg::IDX_W-1:0], 1'b1};
      end
    end else if (cmd.tbl_wr_map) begin
      tbl_wdata = {frame_r, 1'b1};
    end
  end

  // Directory write port
  always_comb begin
    dir_we    = (cmd.clr_step & clr_in_dir) | cmd.dir_alloc;
    dir_waddr = va_r[tlptm_pkg::DI_LSB +: tlptm_pkg::IDX_W];
    dir_wdata = {next_free_r[tlptm_pkg::SLOT_W-1:0], user_r, 1'b1, 1'b1};
    if (cmd.clr_step) begin
      dir_waddr = clr_cnt_r[tlptm_pkg::IDX_W-1:0];
      dir_wdata = '0;
      if (clr_cnt_r == '0) begin
        dir_wdata[tlptm_pkg::ENT_P]  = 1'b1;
        dir_wdata[tlptm_pkg::ENT_WR] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (cmd.capture) begin
      dir_q_r <= dir_mem[in_virt_addr[tlptm_pkg::DI_LSB +: tlptm_pkg::IDX_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (cmd.tbl_rd) begin
      tbl_q_r <= tbl_mem[tbl_addr];
    end
  end

  // Input beat capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= tlptm_pkg::op_t'(in_op);
      va_r    <= in_virt_addr;
      frame_r <= in_frame_addr[31:tlptm_pkg::OFS_W];
      user_r  <= in_entry_flags[tlptm_pkg::ENT_U];
    end
  end

  // Counters and output valid
  always_comb begin
    next_free_nxt = next_free_r;
    if (cmd.dir_alloc) begin
      next_free_nxt = next_free_r + tlptm_pkg::NF_W'(1);
    end
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.clr_step) begin
      clr_cnt_nxt = clr_cnt_r + tlptm_pkg::TBL_AW'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= tlptm_pkg::NF_W'(1);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      next_free_r <= next_free_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.res)
        tlptm_pkg::RES_ZERO: begin
          phys_r   <= '0;
          mapped_r <= 1'b0;
          oot_r    <= 1'b0;
        end
        tlptm_pkg::RES_MAPPED: begin
          phys_r   <= '0;
          mapped_r <= 1'b1;
          oot_r    <= 1'b0;
        end
        tlptm_pkg::RES_OOT: begin
          phys_r   <= '0;
          mapped_r <= 1'b0;
          oot_r    <= 1'b1;
        end
        tlptm_pkg::RES_XLATE: begin
          phys_r   <= tbl_q_r[0] ? {tbl_q_r[tlptm_pkg::FRAME_W:1],
                                    va_r[tlptm_pkg::OFS_W-1:0]} : 32'd0;
          mapped_r <= tbl_q_r[0];
          oot_r    <= 1'b0;
        end
        default: begin
          phys_r   <= '0;
          mapped_r <= 1'b0;
          oot_r    <= 1'b0;
        end
      endcase
    end
  end

  // Status back to the controller
  always_comb begin
    sts.op          = op_r;
    sts.dir_present = dir_present;
    sts.tables_left = (next_free_r < tlptm_pkg::NF_W'(tlptm_pkg::NUM_TABLES));
    sts.out_free    = !out_valid_r || out_ready;
    sts.clr_last    = (clr_cnt_r == tlptm_pkg::TBL_AW'(tlptm_pkg::TBL_DEPTH - 1));
  end

  assign out_valid         = out_valid_r;
  assign out_phys_addr     = phys_r;
  assign out_mapped        = mapped_r;
  assign out_out_of_tables = oot_r;

endmodule

`default_nettype wire

/* src/tlptm_ctrl.sv */
`default_nettype none

module tlptm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tlptm_pkg::sts_t  sts,
  output tlptm_pkg::cmd_t       cmd
);

  tlptm_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlptm_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.res   = tlptm_pkg::RES_ZERO;
    unique case (state_r)
      tlptm_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = tlptm_pkg::ST_IDLE;
        end
      end
      tlptm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = tlptm_pkg::ST_LOOK;
        end
      end
      tlptm_pkg::ST_LOOK: begin
        // directory entry is ready; hold while the result slot is full
        if (sts.out_free) begin
          state_nxt = tlptm_pkg::ST_IDLE;
          unique case (sts.op)
            tlptm_pkg::OP_MAP: begin
              if (sts.dir_present) begin
                cmd.tbl_wr_map = 1'b1;
                cmd.out_load   = 1'b1;
                cmd.res        = tlptm_pkg::RES_MAPPED;
              end else if (sts.tables_left) begin
                cmd.dir_alloc  = 1'b1;
                cmd.tbl_wr_map = 1'b1;
                cmd.out_load   = 1'b1;
                cmd.res        = tlptm_pkg::RES_MAPPED;
              end else begin
                cmd.out_load = 1'b1;
                cmd.res      = tlptm_pkg::RES_OOT;
              end
            end
            tlptm_pkg::OP_UNMAP: begin
              cmd.tbl_wr_clr = sts.dir_present;
              cmd.out_load   = 1'b1;
            end
            tlptm_pkg::OP_XLATE: begin
              if (sts.dir_present) begin
                cmd.tbl_rd = 1'b1;
                state_nxt  = tlptm_pkg::ST_READ;
              end else begin
                cmd.out_load = 1'b1;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      tlptm_pkg::ST_READ: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.res      = tlptm_pkg::RES_XLATE;
          state_nxt    = tlptm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tlptm_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire
